FILE: src/bos_pkg.sv
// Shared constants and types for the box overlap suppression block.
package bos_pkg;

   localparam int MAX_KEPT_DEFAULT = 64;
   localparam int COORD_FRAC_BITS  = 4;

   localparam int COORD_W = 16;   // signed Q12.4 coordinate
   localparam int SPAN_W  = 18;   // signed span after +1 pixel
   localparam int ISPAN_W = 17;   // clamped intersection span
   localparam int AREA_W  = 34;   // signed box area
   localparam int INTER_W = 34;   // unsigned intersection area
   localparam int UNION_W = 36;   // signed union
   localparam int THR_W   = 17;   // unsigned Q1.16 threshold
   localparam int PROD_W  = THR_W + 1 + UNION_W;
   localparam int LHS_W   = INTER_W + 16;
   localparam int CMP_W   = PROD_W + 1;

   localparam logic [THR_W-1:0] THR_RESET = 17'd26214;
   localparam logic signed [SPAN_W-1:0] ONE_PIXEL = SPAN_W'(1 << COORD_FRAC_BITS);

   typedef struct packed {
      logic signed [COORD_W-1:0] left;
      logic signed [COORD_W-1:0] top;
      logic signed [COORD_W-1:0] right;
      logic signed [COORD_W-1:0] bottom;
      logic signed [AREA_W-1:0]  area;
   } kept_entry_type;

endpackage

FILE: src/box_overlap_suppression_top.sv
// Greedy IoU non-maximum suppression against a table of kept boxes.
//
//   channel   ports                       handshake
//   --------  --------------------------  ---------------------------------
//   request   req_start_of_set, req_box_*  start & !busy accepts a beat
//   response  rsp_keep, rsp_table_full,    rsp_strobe, one cycle, no stall
//             rsp_kept_total
//   config    csr_wdata                    csr_we writes the threshold
//
// A beat with n boxes already stored (after any start_of_set clear) runs AREA, SCAN
// (none when n is 0) and DRAIN, then registers rsp_strobe: the kept-box memory feeds
// one stored box per cycle into a five stage compare pipeline, drained before the
// keep decision and write-back. The next beat is taken at the edge ending the strobe.
// Synchronous reset empties the table (count only) and restores the threshold.
// The receiver cannot stall; busy stays high until the strobe cycle.
module box_overlap_suppression_top #(
   parameter  int MAX_KEPT = bos_pkg::MAX_KEPT_DEFAULT,
   localparam int CNT_W    = $clog2(MAX_KEPT + 1)
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic                                  req_start_of_set,
   input  logic signed [bos_pkg::COORD_W-1:0]    req_box_left,
   input  logic signed [bos_pkg::COORD_W-1:0]    req_box_top,
   input  logic signed [bos_pkg::COORD_W-1:0]    req_box_right,
   input  logic signed [bos_pkg::COORD_W-1:0]    req_box_bottom,
   input  logic                                  csr_we,
   input  logic        [bos_pkg::THR_W-1:0]      csr_wdata,
   output logic                                  rsp_strobe,
   output logic                                  rsp_keep,
   output logic                                  rsp_table_full,
   output logic        [CNT_W-1:0]               rsp_kept_total
);

   localparam int IDX_W = $clog2(MAX_KEPT);
   localparam int STAGES = 5;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_AREA  = 2'd1;
   localparam logic [1:0] ST_SCAN  = 2'd2;
   localparam logic [1:0] ST_DRAIN = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic [bos_pkg::THR_W-1:0] thr_ff;
   logic             hit_ff;
   logic [STAGES-1:0] pipe_v_ff;
   logic             issue;
   logic             accept;
   logic             finish;
   logic             store;
   logic             cmp_hit;

   logic signed [bos_pkg::COORD_W-1:0] left_ff, top_ff, right_ff, bottom_ff;
   logic signed [bos_pkg::AREA_W-1:0]  area_ff;

   bos_pkg::kept_entry_type kept_mem [MAX_KEPT];
   bos_pkg::kept_entry_type rd_entry_ff;
   bos_pkg::kept_entry_type wr_entry;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);
   assign issue  = (state_ff == ST_SCAN);
   assign finish = (state_ff == ST_DRAIN) && (pipe_v_ff == '0);
   assign store  = finish && !hit_ff && (count_ff < CNT_W'(MAX_KEPT));

   // ---------------- control
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      scan_in  = scan_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_AREA;
               scan_in  = '0;
               if (req_start_of_set) count_in = '0;
            end
         end
         ST_AREA: begin
            state_in = (count_ff == '0) ? ST_DRAIN : ST_SCAN;
         end
         ST_SCAN: begin
            scan_in = scan_ff + CNT_W'(1);
            if (scan_in == count_ff) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (finish) begin
               state_in = ST_IDLE;
               if (store) count_in = count_ff + CNT_W'(1);
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         scan_ff    <= '0;
         thr_ff     <= bos_pkg::THR_RESET;
         pipe_v_ff  <= '0;
         hit_ff     <= 1'b0;
         rsp_strobe <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         scan_ff    <= scan_in;
         pipe_v_ff  <= {pipe_v_ff[STAGES-2:0], issue};
         rsp_strobe <= finish;
         if (csr_we) thr_ff <= csr_wdata;
         if (accept) hit_ff <= 1'b0;
         else if (pipe_v_ff[STAGES-1] && cmp_hit) hit_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_keep       <= !hit_ff;
         rsp_table_full <= !hit_ff && !store;
         rsp_kept_total <= count_in;
      end
   end

   // ---------------- new box and its area
   logic signed [bos_pkg::SPAN_W-1:0] span_w, span_h;
   logic signed [2*bos_pkg::SPAN_W-1:0] area_full;

   assign span_w = bos_pkg::SPAN_W'(right_ff) - bos_pkg::SPAN_W'(left_ff) + bos_pkg::ONE_PIXEL;
   assign span_h = bos_pkg::SPAN_W'(bottom_ff) - bos_pkg::SPAN_W'(top_ff) + bos_pkg::ONE_PIXEL;
   assign area_full = span_w * span_h;

   always_ff @(posedge clock) begin
      if (accept) begin
         left_ff   <= req_box_left;
         top_ff    <= req_box_top;
         right_ff  <= req_box_right;
         bottom_ff <= req_box_bottom;
      end
      if (state_ff == ST_AREA) area_ff <= bos_pkg::AREA_W'(area_full);
   end

   // ---------------- kept table; the write slot is never one being scanned
   always_comb begin
      wr_entry.left   = left_ff;
      wr_entry.top    = top_ff;
      wr_entry.right  = right_ff;
      wr_entry.bottom = bottom_ff;
      wr_entry.area   = area_ff;
   end

   always_ff @(posedge clock) begin
      if (store) kept_mem[count_ff[IDX_W-1:0]] <= wr_entry;
      rd_entry_ff <= kept_mem[scan_ff[IDX_W-1:0]];
   end

   // ---------------- compare pipeline
   logic signed [bos_pkg::COORD_W-1:0] min_r, max_l, min_b, max_t;
   logic signed [bos_pkg::SPAN_W-1:0]  iw, ih;
   logic [bos_pkg::ISPAN_W-1:0] s1_w_ff, s1_h_ff;
   logic signed [bos_pkg::AREA_W-1:0] s1_area_ff, s2_area_ff;
   logic [bos_pkg::INTER_W-1:0] s2_inter_ff, s3_inter_ff;
   logic signed [bos_pkg::UNION_W-1:0] s3_union_ff;
   logic [bos_pkg::LHS_W-1:0] s4_lhs_ff;
   logic signed [bos_pkg::PROD_W-1:0] s4_prod_ff;
   logic signed [bos_pkg::THR_W:0] thr_s;
   logic signed [bos_pkg::CMP_W-1:0] lhs_ext, rhs_ext;

   assign min_r = (rd_entry_ff.right  < right_ff)  ? rd_entry_ff.right  : right_ff;
   assign max_l = (rd_entry_ff.left   > left_ff)   ? rd_entry_ff.left   : left_ff;
   assign min_b = (rd_entry_ff.bottom < bottom_ff) ? rd_entry_ff.bottom : bottom_ff;
   assign max_t = (rd_entry_ff.top    > top_ff)    ? rd_entry_ff.top    : top_ff;
   assign iw = bos_pkg::SPAN_W'(min_r) - bos_pkg::SPAN_W'(max_l) + bos_pkg::ONE_PIXEL;
   assign ih = bos_pkg::SPAN_W'(min_b) - bos_pkg::SPAN_W'(max_t) + bos_pkg::ONE_PIXEL;

   assign thr_s   = $signed({1'b0, thr_ff});
   assign lhs_ext = $signed({{(bos_pkg::CMP_W - bos_pkg::LHS_W){1'b0}}, s4_lhs_ff});
   assign rhs_ext = bos_pkg::CMP_W'(s4_prod_ff);
   assign cmp_hit = (lhs_ext >= rhs_ext);

   always_ff @(posedge clock) begin
      // stage 1: clamped intersection spans
      s1_w_ff    <= iw[bos_pkg::SPAN_W-1] ? '0 : iw[bos_pkg::ISPAN_W-1:0];
      s1_h_ff    <= ih[bos_pkg::SPAN_W-1] ? '0 : ih[bos_pkg::ISPAN_W-1:0];
      s1_area_ff <= rd_entry_ff.area;
      // stage 2: intersection area
      s2_inter_ff <= bos_pkg::INTER_W'(s1_w_ff * s1_h_ff);
      s2_area_ff  <= s1_area_ff;
      // stage 3: union
      s3_inter_ff <= s2_inter_ff;
      s3_union_ff <= bos_pkg::UNION_W'(s2_area_ff) + bos_pkg::UNION_W'(area_ff)
                     - $signed({2'b00, s2_inter_ff});
      // stage 4: cross-multiplied sides
      s4_lhs_ff  <= {s3_inter_ff, 16'h0000};
      s4_prod_ff <= bos_pkg::PROD_W'(thr_s) * bos_pkg::PROD_W'(s3_union_ff);
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_KEPT))
      else $error("kept count above table size");

   a_idle_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (pipe_v_ff == '0))
      else $error("compare pipeline busy while idle");

   a_full_implies_keep: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (!rsp_table_full || rsp_keep))
      else $error("table_full reported on a suppressed box");

   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(busy) && !busy))
      else $error("response strobe without a beat in flight");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      issue |-> (scan_ff < count_ff))
      else $error("table read beyond kept entries");
`endif

endmodule

FILE: sim/bos_checker.sv
`timescale 1ns / 1ps
// Checker for the NMS block: watches request, response and threshold writes, predicts and compares.
module bos_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic                               busy,
   input  logic                               req_start_of_set,
   input  logic signed [bos_pkg::COORD_W-1:0] req_box_left,
   input  logic signed [bos_pkg::COORD_W-1:0] req_box_top,
   input  logic signed [bos_pkg::COORD_W-1:0] req_box_right,
   input  logic signed [bos_pkg::COORD_W-1:0] req_box_bottom,
   input  logic                               csr_we,
   input  logic        [bos_pkg::THR_W-1:0]   csr_wdata,
   input  logic                               rsp_strobe,
   input  logic                               rsp_keep,
   input  logic                               rsp_table_full,
   input  logic        [6:0]                  rsp_kept_total,
   output int                                 error_count,
   output int                                 pending,
   output int                                 kept_seen,
   output int                                 dropped_seen,
   output int                                 unstored_seen
);

   localparam int     TABLE_DEPTH = bos_pkg::MAX_KEPT_DEFAULT;
   localparam longint PIXEL       = longint'(1) << bos_pkg::COORD_FRAC_BITS;

   typedef struct packed {
      logic       keep;
      logic       table_full;
      logic [6:0] kept_total;
   } verdict_type;

   logic [bos_pkg::THR_W-1:0] threshold = bos_pkg::THR_RESET;
   longint           held_box[TABLE_DEPTH][4];
   longint           held_area[TABLE_DEPTH];
   int               held_count = 0;
   int               beat_index = 0;
   verdict_type      verdict_q[$];

   // Greedy suppression of one box against the boxes held for the current set.
   function automatic verdict_type suppress_box(input logic sos, input longint l,
                                                input longint t, input longint r,
                                                input longint b);
      longint      area, iw, ih, inter, uni;
      logic        keep_it;
      verdict_type v;
      if (sos)
         held_count = 0;
      area = (r - l + PIXEL) * (b - t + PIXEL);
      keep_it = 1'b1;
      for (int i = 0; i < held_count && keep_it; i++) begin
         iw = ((held_box[i][2] < r) ? held_box[i][2] : r)
              - ((held_box[i][0] > l) ? held_box[i][0] : l) + PIXEL;
         ih = ((held_box[i][3] < b) ? held_box[i][3] : b)
              - ((held_box[i][1] > t) ? held_box[i][1] : t) + PIXEL;
         if (iw < 0) iw = 0;
         if (ih < 0) ih = 0;
         inter = iw * ih;
         uni = held_area[i] + area - inter;
         // cross-multiplied IoU test, signed union taken as is
         if (inter * 65536 >= longint'(threshold) * uni)
            keep_it = 1'b0;
      end
      v.keep = keep_it;
      v.table_full = 1'b0;
      if (keep_it) begin
         if (held_count < TABLE_DEPTH) begin
            held_box[held_count] = '{l, t, r, b};
            held_area[held_count] = area;
            held_count++;
         end else begin
            v.table_full = 1'b1;
         end
      end
      v.kept_total = 7'(held_count);
      return v;
   endfunction

   always @(posedge clock) begin : watch
      verdict_type want, got;
      if (reset) begin
         threshold = bos_pkg::THR_RESET;
         held_count = 0;
         verdict_q.delete();
      end else begin
         // retire the result first: a beat accepted at this edge cannot answer here
         if (rsp_strobe) begin
            got = {rsp_keep, rsp_table_full, rsp_kept_total};
            if (verdict_q.size() == 0) begin
               if (error_count < 10)
                  $display("unexpected result: keep=%0d full=%0d total=%0d",
                           got.keep, got.table_full, got.kept_total);
               error_count++;
            end else begin
               want = verdict_q.pop_front();
               if (got.keep !== want.keep || got.table_full !== want.table_full
                   || got.kept_total !== want.kept_total) begin
                  if (error_count < 10)
                     $display({"mismatch beat %0d: expected keep=%0d full=%0d total=%0d,",
                               " got keep=%0d full=%0d total=%0d"},
                              beat_index, want.keep, want.table_full, want.kept_total,
                              got.keep, got.table_full, got.kept_total);
                  error_count++;
               end
               if (!want.keep)
                  dropped_seen++;
               else if (want.table_full)
                  unstored_seen++;
               else
                  kept_seen++;
               beat_index++;
            end
         end
         if (start && !busy)
            verdict_q.push_back(suppress_box(req_start_of_set, req_box_left, req_box_top,
                                             req_box_right, req_box_bottom));
         if (csr_we)
            threshold = csr_wdata;
      end
      pending = verdict_q.size();
   end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// Testbench top: box stimulus, threshold phases and the run verdict.
module tb;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int PHASE_BOXES = 110;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               start = 1'b0;
   logic                               busy;
   logic                               req_start_of_set = 1'b0;
   logic signed [bos_pkg::COORD_W-1:0] req_box_left = '0;
   logic signed [bos_pkg::COORD_W-1:0] req_box_top = '0;
   logic signed [bos_pkg::COORD_W-1:0] req_box_right = '0;
   logic signed [bos_pkg::COORD_W-1:0] req_box_bottom = '0;
   logic                               csr_we = 1'b0;
   logic        [bos_pkg::THR_W-1:0]   csr_wdata = '0;
   logic                               rsp_strobe;
   logic                               rsp_keep;
   logic                               rsp_table_full;
   logic        [6:0]                  rsp_kept_total;

   int error_count, pending, kept_seen, dropped_seen, unstored_seen;
   int cycle_count = 0;
   int boxes_sent = 0;
   int thresholds_written = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   box_overlap_suppression_top u_top (
      .clock, .reset, .start, .busy,
      .req_start_of_set, .req_box_left, .req_box_top, .req_box_right, .req_box_bottom,
      .csr_we, .csr_wdata,
      .rsp_strobe, .rsp_keep, .rsp_table_full, .rsp_kept_total
   );

   bos_checker u_check (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
         $display("tb: errors");
         $finish;
      end
   end

   // Present one beat and hold it until accepted; start stays high afterwards.
   task automatic send_box(input logic sos, input int l, input int t, input int r, input int b);
      start <= 1'b1;
      req_start_of_set <= sos;
      req_box_left <= 16'(l);
      req_box_top <= 16'(t);
      req_box_right <= 16'(r);
      req_box_bottom <= 16'(b);
      do @(posedge clock); while (busy);
      boxes_sent++;
   endtask

   task automatic pause(input int n);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // pending is sampled on the falling edge, away from checker updates
   task automatic drain();
      start <= 1'b0;
      do @(negedge clock); while (pending != 0);
      @(posedge clock);
   endtask

   task automatic write_threshold(input int value);
      drain();
      csr_we <= 1'b1;
      csr_wdata <= bos_pkg::THR_W'(value);
      @(posedge clock);
      csr_we <= 1'b0;
      thresholds_written++;
   endtask

   function automatic int pick_gap(input bit quiet);
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 15);
      return $urandom_range(20, 80);
   endfunction

   function automatic int jitter(input int span);
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   // One set of boxes: clusters, table-filling grids, near duplicates or raw noise.
   task automatic emit_set();
      int  mode, n, cx, cy, w, h, slot, pl, pt, pr, pb;
      bit  quiet;
      quiet = ($urandom_range(0, 3) == 0);
      mode = $urandom_range(0, 99);
      if (mode < 55) begin
         n = $urandom_range(1, 24);
         cx = int'($urandom_range(0, 56000)) - 28000;
         cy = int'($urandom_range(0, 56000)) - 28000;
         for (int k = 0; k < n; k++) begin
            pl = cx + jitter(512);
            pt = cy + jitter(512);
            w = $urandom_range(16, 1024);
            h = $urandom_range(16, 1024);
            if ($urandom_range(0, 9) == 0)
               send_box(k == 0, pl + w - 1, pt, pl, pt + h - 1);
            else
               send_box(k == 0, pl, pt, pl + w - 1, pt + h - 1);
            pause(pick_gap(quiet));
         end
      end else if (mode < 70) begin
         // disjoint slots of a 9x9 grid, 60 to 72 boxes, which can overrun the table
         n = $urandom_range(60, 72);
         slot = $urandom_range(0, 80);
         for (int k = 0; k < n; k++) begin
            if (k == 0 || $urandom_range(0, 9) != 0) begin
               pl = -32768 + (slot % 9) * 7200 + int'($urandom_range(0, 200));
               pt = -32768 + (slot / 9) * 7200 + int'($urandom_range(0, 200));
               pr = pl + int'($urandom_range(16, 6900)) - 1;
               pb = pt + int'($urandom_range(16, 6900)) - 1;
               slot = (slot + 1) % 81;
            end
            send_box(k == 0, pl, pt, pr, pb);
            pause(pick_gap(quiet));
         end
      end else if (mode < 85) begin
         n = $urandom_range(2, 10);
         pl = int'($urandom_range(0, 40000)) - 20000;
         pt = int'($urandom_range(0, 40000)) - 20000;
         w = $urandom_range(32, 4000);
         h = $urandom_range(32, 4000);
         for (int k = 0; k < n; k++) begin
            send_box(k == 0, pl + jitter(64), pt + jitter(64),
                     pl + w - 1 + jitter(64), pt + h - 1 + jitter(64));
            pause(pick_gap(quiet));
         end
      end else begin
         n = $urandom_range(1, 8);
         for (int k = 0; k < n; k++) begin
            send_box(1'($urandom_range(0, 1)), $urandom_range(0, 65535),
                     $urandom_range(0, 65535), $urandom_range(0, 65535),
                     $urandom_range(0, 65535));
            pause(pick_gap(quiet));
         end
      end
   endtask

   initial begin
      int thr_plan[10];
      int phase_mark;
      thr_plan = '{26214, 32768, 0, 65536, 131071, 1, 65535, 16384, 0, 0};
      thr_plan[8] = $urandom_range(0, 131071);
      thr_plan[9] = $urandom_range(0, 65536);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed boxes under the reset threshold
      send_box(1'b1, 0, 0, 159, 159);                 // new set on an empty table
      send_box(1'b0, 0, 0, 159, 159);                 // identical box
      pause(pick_gap(1'b0));
      send_box(1'b0, -32768, -32768, 32767, 32767);   // whole plane
      send_box(1'b0, 100, 0, -200, 159);              // inverted, negative union
      send_box(1'b0, -32768, -32768, -32768, -32768);
      pause(pick_gap(1'b0));
      send_box(1'b0, 32767, 32767, 32767, 32767);
      send_box(1'b1, 32767, -32768, -32768, 32767);   // inverted in x
      send_box(1'b0, 0, 0, 15, 15);
      send_box(1'b1, -16, -16, -1, -1);

      write_threshold(0);                             // zero threshold drops disjoint boxes
      send_box(1'b1, 0, 0, 99, 99);
      send_box(1'b0, 5000, 5000, 5099, 5099);

      write_threshold(65536);                         // threshold of exactly one
      send_box(1'b1, 0, 0, 99, 99);
      send_box(1'b0, 0, 0, 99, 99);
      send_box(1'b0, 0, 0, 99, 100);

      write_threshold(131071);                        // above one: even duplicates pass
      send_box(1'b1, 0, 0, 99, 99);
      send_box(1'b0, 0, 0, 99, 99);
      send_box(1'b1, 0, 0, 99, 99);
      send_box(1'b1, 0, 0, -16, 99);                  // zero-area box, zero union next
      send_box(1'b0, 0, 0, -16, 99);

      foreach (thr_plan[p]) begin
         write_threshold(thr_plan[p]);
         phase_mark = boxes_sent;
         while (boxes_sent - phase_mark < PHASE_BOXES) begin
            emit_set();
            if ($urandom_range(0, 19) == 0)
               drain();
         end
      end

      drain();
      repeat (80) @(posedge clock);

      $display("summary: %0d boxes over %0d threshold settings in %0d cycles",
               boxes_sent, thresholds_written, cycle_count);
      $display("summary: %0d kept and stored, %0d suppressed, %0d kept with the table full",
               kept_seen, dropped_seen, unstored_seen);
      if (error_count == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule

FILE: filelist.f
src/bos_pkg.sv
src/box_overlap_suppression_top.sv
sim/bos_checker.sv
sim/tb.sv
